@@ hw/rtl/alqb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alqb_pkg
// shared types and constants of the adaptive queue load balancer
// ----------------------------------------------------------------------------
package alqb_pkg;

    localparam int QID_W       = 3;
    localparam int MAX_QUEUES  = 8;      // one counter set per queue_id code
    localparam int OBJ_W       = 8;
    localparam int MAX_OBJECTS = 256;    // one entry per object_id code
    localparam int COUNT_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int FRAC_W      = 16;
    localparam int METRIC_W    = 21;     // signed q4.16 plus room for the start value
    localparam int SPREAD_W    = 20;
    localparam int STREAK_W    = 16;
    localparam int NQ_W        = 4;
    localparam int NOBJ_W      = 9;
    localparam int TIMER_W     = 32;
    localparam int MIN_START   = 1000000;
    localparam int NEG_LIMIT   = 524288;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 56;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 32;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ROLL   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_INTV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_INTV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECTS     = 3'd6;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic ev_commit;
        logic chk_init;
        logic q_start;
        logic q_update;
        logic o_start;
        logic o_update;
        logic move_wr;
        logic base_q;
        logic base_wr;
        logic idx_clr;
        logic idx_inc;
        logic out_load;
    } alqb_cmd_t;

    typedef struct packed {
        logic in_event;
        logic chk_due;
        logic m_done;
        logic last_q;
        logic last_o;
        logic last_all;
        logic reb;
        logic eligible;
        logic own_match;
        logic out_busy;
    } alqb_status_t;

endpackage

@@ hw/rtl/adaptive_queue_load_balancer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_queue_load_balancer_core
// per-object and per-queue event counting with periodic queue rebalancing
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_*       in         request: tuser func, tdata object_id, queue_id
// m_*       out        check result, one per check that runs
// cfg_*     in         register writes, index 0..6
//
// counting requests are accepted, then written in a state of their own (S_EV);
// owner assignments and ticks without a check are taken in the idle state alone
// a check sweeps the queues through a one-bit-per-cycle divider; on a rebalance
// between distinct queues it sweeps the objects owned by the highest-metric queue,
// then copies baselines for the objects in use, which it also does with no rebalance
// after reset a clearing pass runs over all 256 object memory entries first
// a result waiting on m_tready holds the next check only at its end
// ----------------------------------------------------------------------------
module adaptive_queue_load_balancer_core #(
    parameter int COUNT_WIDTH = alqb_pkg::COUNT_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [alqb_pkg::IN_W-1:0]      s_tdata,   // object_id, queue_id
    input  logic [alqb_pkg::FUNC_W-1:0]    s_tuser,   // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rebalanced, moved, moved_object, from_queue, to_queue, spread, relaxed_mode, streak
    output logic [alqb_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_wen,
    input  logic [alqb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [alqb_pkg::CFG_W-1:0]     cfg_wdata
);
    import alqb_pkg::*;

    alqb_cmd_t    cmd;
    alqb_status_t status;

    alqb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    alqb_datapath #(
        .CW (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a counted event blocks the next request for its write cycle
    a_event_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && status.in_event |=> !s_tready)
        else $error("event request not given its commit cycle");

    a_moved_needs_rebalance: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && m_tdata[12:10] != m_tdata[15:13])
        else $error("move reported without a rebalance between distinct queues");

    a_load_not_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten while still pending");

endmodule

@@ hw/rtl/alqb_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alqb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module alqb_div #(
    parameter int CW = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CW+15:0]     dividend,
    input  logic [CW-1:0]      divisor,
    output logic               done,
    output logic [CW+15:0]     quotient
);
    localparam int DW  = CW + 16;
    localparam int CNW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNW-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [CW:0]     r_reg, r_next;
    logic [CW-1:0]   d_reg, d_next;
    logic [CW:0]     shifted;
    logic            fits;

    assign shifted = {r_reg[CW-1:0], q_reg[DW-1]};
    assign fits    = shifted >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNW'(DW);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            r_next   = fits ? shifted - {1'b0, d_reg} : shifted;
            q_next   = {q_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hw/rtl/alqb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alqb_datapath
// counters, object memories, metric unit, selection and result register
// ----------------------------------------------------------------------------
module alqb_datapath #(
    parameter int CW = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [alqb_pkg::IN_W-1:0]     s_tdata,
    input  logic [alqb_pkg::FUNC_W-1:0]   s_tuser,
    input  logic                          cfg_wen,
    input  logic [alqb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [alqb_pkg::CFG_W-1:0]    cfg_wdata,
    input  alqb_pkg::alqb_cmd_t           cmd,
    output alqb_pkg::alqb_status_t        status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [alqb_pkg::OUT_W-1:0]    m_tdata
);
    import alqb_pkg::*;

    localparam int DW = CW + FRAC_W;

    // configuration
    logic [SPREAD_W-1:0] thr_reg;
    logic [TIMER_W-1:0]  nintv_reg, rintv_reg;
    logic [STREAK_W-1:0] nlim_reg, rlim_reg;
    logic [NQ_W-1:0]     nq_cfg_reg;
    logic [NOBJ_W-1:0]   nobj_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= SPREAD_W'(6554);
            nintv_reg    <= TIMER_W'(1000);
            nlim_reg     <= STREAK_W'(4);
            rintv_reg    <= TIMER_W'(4000);
            rlim_reg     <= STREAK_W'(2);
            nq_cfg_reg   <= NQ_W'(8);
            nobj_cfg_reg <= NOBJ_W'(256);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_SPREAD_THR:  thr_reg      <= cfg_wdata[SPREAD_W-1:0];
                REG_NORM_INTV:   nintv_reg    <= cfg_wdata[TIMER_W-1:0];
                REG_NORM_LIMIT:  nlim_reg     <= cfg_wdata[STREAK_W-1:0];
                REG_RELAX_INTV:  rintv_reg    <= cfg_wdata[TIMER_W-1:0];
                REG_RELAX_LIMIT: rlim_reg     <= cfg_wdata[STREAK_W-1:0];
                REG_QUEUES:      nq_cfg_reg   <= cfg_wdata[NQ_W-1:0];
                REG_OBJECTS:     nobj_cfg_reg <= cfg_wdata[NOBJ_W-1:0];
                default: ;
            endcase
        end
    end

    logic [NQ_W-1:0]   nq;
    logic [NOBJ_W-1:0] nobj;

    always_comb
    begin
        nq = nq_cfg_reg;
        if (nq_cfg_reg == '0)
            nq = NQ_W'(1);
        else if (nq_cfg_reg > NQ_W'(MAX_QUEUES))
            nq = NQ_W'(MAX_QUEUES);
        nobj = nobj_cfg_reg;
        if (nobj_cfg_reg == '0)
            nobj = NOBJ_W'(1);
        else if (nobj_cfg_reg > NOBJ_W'(MAX_OBJECTS))
            nobj = NOBJ_W'(MAX_OBJECTS);
    end

    // request fields
    logic [FUNC_W-1:0] in_func;
    logic [OBJ_W-1:0]  in_obj;
    logic [QID_W-1:0]  in_qid;
    logic              in_range;

    assign in_func  = s_tuser;
    assign in_obj   = s_tdata[OBJ_W-1:0];
    assign in_qid   = s_tdata[OBJ_W+QID_W-1:OBJ_W];
    assign in_range = {1'b0, in_obj} < nobj;

    // index counter shared by all sweeps
    logic [OBJ_W-1:0] idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.idx_clr || cmd.chk_init)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
    end

    // object memories, {rolled, committed}
    logic [2*CW-1:0]  cnt_mem [MAX_OBJECTS];
    logic [2*CW-1:0]  base_mem [MAX_OBJECTS];
    logic [QID_W-1:0] own_mem [MAX_OBJECTS];
    logic [2*CW-1:0]  cnt_rd, base_rd;
    logic [QID_W-1:0] own_rd;
    logic [OBJ_W-1:0] rd_addr;
    logic [OBJ_W-1:0] ev_obj_reg;
    logic             ev_roll_reg;

    // move bookkeeping
    logic [OBJ_W-1:0] best_reg;
    logic             best_valid_reg;
    logic [QID_W-1:0] from_reg, to_reg;

    assign rd_addr = cmd.accept ? in_obj : idx_reg;

    always_ff @(posedge clk)
    begin
        cnt_rd  <= cnt_mem[rd_addr];
        base_rd <= base_mem[rd_addr];
        own_rd  <= own_mem[rd_addr];
        if (cmd.accept)
        begin
            ev_obj_reg  <= in_obj;
            ev_roll_reg <= in_func == FUNC_ROLL;
        end
        if (cmd.clr_wr)
            cnt_mem[idx_reg] <= '0;
        else if (cmd.ev_commit)
            cnt_mem[ev_obj_reg] <= ev_roll_reg
                ? {cnt_rd[2*CW-1:CW] + 1'b1, cnt_rd[CW-1:0]}
                : {cnt_rd[2*CW-1:CW], cnt_rd[CW-1:0] + 1'b1};
        if (cmd.clr_wr)
            base_mem[idx_reg] <= '0;
        else if (cmd.base_wr)
            base_mem[idx_reg] <= cnt_rd;
        if (cmd.clr_wr)
            own_mem[idx_reg] <= '0;
        else if (cmd.accept && in_func == FUNC_ASSIGN && in_range)
            own_mem[in_obj] <= in_qid;
        else if (cmd.move_wr && best_valid_reg)
            own_mem[best_reg] <= to_reg;
    end

    // queue counters
    logic [CW-1:0]    q_cmt [MAX_QUEUES];
    logic [CW-1:0]    q_rol [MAX_QUEUES];
    logic [CW-1:0]    q_cbase [MAX_QUEUES];
    logic [CW-1:0]    q_rbase [MAX_QUEUES];
    logic [QID_W-1:0] q_addr;

    assign q_addr = cmd.ev_commit ? own_rd : idx_reg[QID_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                q_cmt[i]   <= '0;
                q_rol[i]   <= '0;
                q_cbase[i] <= '0;
                q_rbase[i] <= '0;
            end
        end
        else
        begin
            if (cmd.ev_commit)
            begin
                if (ev_roll_reg)
                    q_rol[q_addr] <= q_rol[q_addr] + 1'b1;
                else
                    q_cmt[q_addr] <= q_cmt[q_addr] + 1'b1;
            end
            if (cmd.base_q)
            begin
                for (int i = 0; i < MAX_QUEUES; i++)
                begin
                    if (NQ_W'(i) < nq)
                    begin
                        q_cbase[i] <= q_cmt[i];
                        q_rbase[i] <= q_rol[i];
                    end
                end
            end
        end
    end

    // efficiency unit
    logic [CW-1:0]  c_sel, r_sel, diff;
    logic           any_start, neg_reg, zero_reg;
    logic           div_done;
    logic [DW-1:0]  quo;
    logic signed [METRIC_W-1:0] metric;

    always_comb
    begin
        if (cmd.q_start)
        begin
            c_sel = q_cmt[q_addr] - q_cbase[q_addr];
            r_sel = q_rol[q_addr] - q_rbase[q_addr];
        end
        else
        begin
            c_sel = cnt_rd[CW-1:0] - base_rd[CW-1:0];
            r_sel = cnt_rd[2*CW-1:CW] - base_rd[2*CW-1:CW];
        end
        diff = (r_sel > c_sel) ? r_sel - c_sel : c_sel - r_sel;
    end

    assign any_start = cmd.q_start || cmd.o_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zero_reg <= 1'b0;
        else
            zero_reg <= any_start && c_sel == '0;
    end

    always_ff @(posedge clk)
    begin
        if (any_start)
            neg_reg <= r_sel > c_sel;
    end

    alqb_div #(
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (any_start && c_sel != '0),
        .dividend ({diff, FRAC_W'(0)}),
        .divisor  (c_sel),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        if (zero_reg)
            metric = '0;
        else if (!neg_reg)
            metric = $signed({1'b0, quo[METRIC_W-2:0]});
        else if (quo > DW'(NEG_LIMIT))
            metric = -METRIC_W'(NEG_LIMIT);
        else
            metric = -$signed({1'b0, quo[METRIC_W-2:0]});
    end

    // check state
    logic signed [METRIC_W-1:0] max_reg, min_reg, bestv_reg;
    logic                       from_valid_reg, moved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            moved_reg      <= 1'b0;
        end
        else if (cmd.chk_init)
        begin
            from_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            moved_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.q_update && metric > max_reg)
                from_valid_reg <= 1'b1;
            if (cmd.o_update && metric > bestv_reg)
                best_valid_reg <= 1'b1;
            if (cmd.move_wr)
                moved_reg <= best_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chk_init)
        begin
            max_reg   <= '0;
            min_reg   <= METRIC_W'(MIN_START);
            bestv_reg <= '0;
            from_reg  <= '0;
            to_reg    <= '0;
            best_reg  <= '0;
        end
        else
        begin
            if (cmd.q_update)
            begin
                if (metric > max_reg)
                begin
                    max_reg  <= metric;
                    from_reg <= idx_reg[QID_W-1:0];
                end
                if (metric < min_reg)
                begin
                    min_reg <= metric;
                    to_reg  <= idx_reg[QID_W-1:0];
                end
            end
            if (cmd.o_update && metric > bestv_reg)
            begin
                bestv_reg <= metric;
                best_reg  <= idx_reg;
            end
        end
    end

    logic signed [METRIC_W:0] spread_full;
    logic [SPREAD_W-1:0]      spread;
    logic                     reb;

    assign spread_full = {max_reg[METRIC_W-1], max_reg} - {min_reg[METRIC_W-1], min_reg};
    assign spread      = spread_full[SPREAD_W-1:0];
    assign reb         = spread >= thr_reg;

    // quiet timer and mode
    logic [TIMER_W-1:0]  timer_reg, timer_inc;
    logic                due;
    logic                relaxed_reg, relaxed_new;
    logic [STREAK_W-1:0] streak_reg, streak_new;
    logic [STREAK_W:0]   streak_step;
    logic [STREAK_W-1:0] streak_sat;

    assign timer_inc = (timer_reg == '1) ? timer_reg : timer_reg + 1'b1;
    assign due       = timer_inc > (relaxed_reg ? rintv_reg : nintv_reg);

    always_comb
    begin
        if (reb == relaxed_reg)
            streak_step = {1'b0, streak_reg} + 1'b1;
        else
            streak_step = '0;
        streak_sat  = streak_step[STREAK_W] ? '1 : streak_step[STREAK_W-1:0];
        relaxed_new = relaxed_reg;
        streak_new  = streak_sat;
        if (streak_sat >= (relaxed_reg ? rlim_reg : nlim_reg))
        begin
            relaxed_new = !relaxed_reg;
            streak_new  = '0;
        end
    end

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg     <= '0;
            relaxed_reg   <= 1'b0;
            streak_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && in_func == FUNC_TICK)
                timer_reg <= due ? '0 : timer_inc;
            if (cmd.out_load)
            begin
                relaxed_reg   <= relaxed_new;
                streak_reg    <= streak_new;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= {3'b000, streak_new, relaxed_new, spread, to_reg,
                        from_valid_reg ? from_reg : QID_W'(0),
                        moved_reg ? best_reg : OBJ_W'(0), moved_reg, reb};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign status.in_event  = (in_func == FUNC_COMMIT || in_func == FUNC_ROLL) && in_range;
    assign status.chk_due   = in_func == FUNC_TICK && due;
    assign status.m_done    = div_done || zero_reg;
    assign status.last_q    = {1'b0, idx_reg} == {{(NOBJ_W-NQ_W){1'b0}}, nq} - 1'b1;
    assign status.last_o    = {1'b0, idx_reg} == nobj - 1'b1;
    assign status.last_all  = idx_reg == OBJ_W'(MAX_OBJECTS - 1);
    assign status.reb       = reb;
    assign status.eligible  = from_valid_reg && from_reg != to_reg;
    assign status.own_match = own_rd == from_reg;
    assign status.out_busy  = out_valid_reg && !m_tready;

endmodule

@@ hw/rtl/alqb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alqb_ctrl
// sequencer for the clearing pass, counting, the queue and object sweeps, baselines and the result
// ----------------------------------------------------------------------------
module alqb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  alqb_pkg::alqb_status_t status,
    output alqb_pkg::alqb_cmd_t    cmd
);
    import alqb_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EV     = 4'd2;
    localparam logic [3:0] S_QSTART = 4'd3;
    localparam logic [3:0] S_QWAIT  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_ORD    = 4'd6;
    localparam logic [3:0] S_OCHK   = 4'd7;
    localparam logic [3:0] S_OWAIT  = 4'd8;
    localparam logic [3:0] S_MOVE   = 4'd9;
    localparam logic [3:0] S_BRD    = 4'd10;
    localparam logic [3:0] S_BWR    = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] state_reg, state_next;

    assign s_tready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                if (status.last_all)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_event)
                        state_next = S_EV;
                    else if (status.chk_due)
                    begin
                        cmd.chk_init = 1'b1;
                        state_next   = S_QSTART;
                    end
                end
            end
            S_EV:
            begin
                cmd.ev_commit = 1'b1;
                state_next    = S_IDLE;
            end
            S_QSTART:
            begin
                cmd.q_start = 1'b1;
                state_next  = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (status.m_done)
                begin
                    cmd.q_update = 1'b1;
                    if (status.last_q)
                        state_next = S_DECIDE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_QSTART;
                    end
                end
            end
            S_DECIDE:
            begin
                cmd.idx_clr = 1'b1;
                if (status.reb && status.eligible)
                    state_next = S_ORD;
                else if (status.reb)
                    state_next = S_OUT;
                else
                begin
                    cmd.base_q = 1'b1;
                    state_next = S_BRD;
                end
            end
            S_ORD:
                state_next = S_OCHK;
            S_OCHK:
            begin
                if (status.own_match)
                begin
                    cmd.o_start = 1'b1;
                    state_next  = S_OWAIT;
                end
                else if (status.last_o)
                    state_next = S_MOVE;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_ORD;
                end
            end
            S_OWAIT:
            begin
                if (status.m_done)
                begin
                    cmd.o_update = 1'b1;
                    if (status.last_o)
                        state_next = S_MOVE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_ORD;
                    end
                end
            end
            S_MOVE:
            begin
                cmd.move_wr = 1'b1;
                cmd.base_q  = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = S_BRD;
            end
            S_BRD:
                state_next = S_BWR;
            S_BWR:
            begin
                cmd.base_wr = 1'b1;
                if (status.last_o)
                    state_next = S_OUT;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_BRD;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

@@ sim/tb_adaptive_queue_load_balancer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_queue_load_balancer_core
// stream testbench: drives event, owner and tick requests, predicts each check
// result in a local copy of the balancer state and compares field by field
// ----------------------------------------------------------------------------
module tb_adaptive_queue_load_balancer_core;
    import alqb_pkg::*;

    localparam int  PAUSE_CYCLES = 14000;   // longest check sweep with 256 objects
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [OBJ_W-1:0]  object_id;
        logic [QID_W-1:0]  queue_id;
    } request_t;

    typedef struct {
        logic              rebalanced;
        logic              moved;
        logic [OBJ_W-1:0]  moved_object;
        logic [QID_W-1:0]  from_queue;
        logic [QID_W-1:0]  to_queue;
        logic [SPREAD_W-1:0] spread;
        logic              relaxed_mode;
        logic [STREAK_W-1:0] streak;
    } check_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    adaptive_queue_load_balancer_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow registers
    logic [19:0] thr;
    logic [31:0] norm_intv, relax_intv;
    logic [15:0] norm_limit, relax_limit;
    logic [3:0]  nq_reg;
    logic [8:0]  nobj_reg;

    // shadow balancer state
    logic [31:0] q_com [MAX_QUEUES];
    logic [31:0] q_rol [MAX_QUEUES];
    logic [31:0] q_com_b [MAX_QUEUES];
    logic [31:0] q_rol_b [MAX_QUEUES];
    logic [31:0] o_com [MAX_OBJECTS];
    logic [31:0] o_rol [MAX_OBJECTS];
    logic [31:0] o_com_b [MAX_OBJECTS];
    logic [31:0] o_rol_b [MAX_OBJECTS];
    logic [QID_W-1:0] owner [MAX_OBJECTS];
    logic        relaxed;
    logic [15:0] streak_cnt;
    logic [31:0] quiet;

    request_t pending_reqs[$];
    check_t   expected_checks[$];
    int       errors = 0;
    int       s_idle_pct = 0;
    int       m_idle_pct = 0;
    bit       s_taken = 0;
    longint   cycles = 0;

    function automatic logic signed [31:0] efficiency(logic [31:0] c, logic [31:0] cb,
                                                      logic [31:0] r, logic [31:0] rb);
        logic [31:0] dc;
        logic [31:0] dr;
        logic [63:0] mag;
        dc = c - cb;
        dr = r - rb;
        if (dc == 0)
            return 0;
        if (dr <= dc)
        begin
            mag = ({32'd0, dc - dr} << 16) / {32'd0, dc};
            return $signed(mag[31:0]);
        end
        mag = ({32'd0, dr - dc} << 16) / {32'd0, dc};
        if (mag > NEG_LIMIT)
            mag = NEG_LIMIT;
        return -$signed(mag[31:0]);
    endfunction

    function automatic int queues_eff();
        if (nq_reg < 1) return 1;
        if (nq_reg > MAX_QUEUES) return MAX_QUEUES;
        return nq_reg;
    endfunction

    function automatic int objects_eff();
        if (nobj_reg < 1) return 1;
        if (nobj_reg > MAX_OBJECTS) return MAX_OBJECTS;
        return nobj_reg;
    endfunction

    task automatic copy_baselines();
        for (int i = 0; i < queues_eff(); i++)
        begin
            q_com_b[i] = q_com[i];
            q_rol_b[i] = q_rol[i];
        end
        for (int i = 0; i < objects_eff(); i++)
        begin
            o_com_b[i] = o_com[i];
            o_rol_b[i] = o_rol[i];
        end
    endtask

    task automatic apply_request(request_t rq);
        logic [31:0] intv;
        logic signed [31:0] maxv;
        logic signed [31:0] minv;
        logic signed [31:0] m;
        logic signed [31:0] bestv;
        logic [31:0] spr;
        logic [16:0] st;
        int from_q;
        int to_q;
        int best;
        bit reb;
        check_t res;
        from_q = -1;
        to_q = -1;
        best = -1;
        if (rq.func != FUNC_TICK)
        begin
            if (rq.object_id >= objects_eff())
                return;
            case (rq.func)
                FUNC_ASSIGN: owner[rq.object_id] = rq.queue_id;
                FUNC_COMMIT:
                begin
                    o_com[rq.object_id]++;
                    q_com[owner[rq.object_id]]++;
                end
                default:
                begin
                    o_rol[rq.object_id]++;
                    q_rol[owner[rq.object_id]]++;
                end
            endcase
            return;
        end
        if (quiet != 32'hFFFF_FFFF)
            quiet++;
        intv = relaxed ? relax_intv : norm_intv;
        if (quiet <= intv)
            return;
        quiet = 0;
        maxv = 0;
        minv = MIN_START;
        for (int i = 0; i < queues_eff(); i++)
        begin
            m = efficiency(q_com[i], q_com_b[i], q_rol[i], q_rol_b[i]);
            if (m > maxv)
            begin
                maxv = m;
                from_q = i;
            end
            if (m < minv)
            begin
                minv = m;
                to_q = i;
            end
        end
        spr = maxv - minv;
        reb = spr >= thr;
        res.moved = 1'b0;
        if (reb)
        begin
            if (from_q >= 0 && from_q != to_q)
            begin
                bestv = 0;
                for (int i = 0; i < objects_eff(); i++)
                begin
                    if (owner[i] != from_q)
                        continue;
                    m = efficiency(o_com[i], o_com_b[i], o_rol[i], o_rol_b[i]);
                    if (m > bestv)
                    begin
                        bestv = m;
                        best = i;
                    end
                end
                if (best >= 0)
                begin
                    owner[best] = to_q[QID_W-1:0];
                    res.moved = 1'b1;
                end
                copy_baselines();
            end
            st = relaxed ? streak_cnt + 17'd1 : 17'd0;
        end
        else
        begin
            copy_baselines();
            st = relaxed ? 17'd0 : streak_cnt + 17'd1;
        end
        streak_cnt = (st > 17'hFFFF) ? 16'hFFFF : st[15:0];
        if (!relaxed)
        begin
            if (streak_cnt >= norm_limit)
            begin
                relaxed = 1'b1;
                streak_cnt = '0;
            end
        end
        else if (streak_cnt >= relax_limit)
        begin
            relaxed = 1'b0;
            streak_cnt = '0;
        end
        res.rebalanced = reb;
        res.moved_object = res.moved ? best[OBJ_W-1:0] : '0;
        res.from_queue = (from_q >= 0) ? from_q[QID_W-1:0] : '0;
        res.to_queue = (to_q >= 0) ? to_q[QID_W-1:0] : '0;
        res.spread = spr[SPREAD_W-1:0];
        res.relaxed_mode = relaxed;
        res.streak = streak_cnt;
        expected_checks.push_back(res);
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        request_t nxt;
        if (rst_n)
        begin
            if (!s_tvalid || s_taken)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= s_idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    s_tuser <= nxt.func;
                    s_tdata <= {5'b00000, nxt.queue_id, nxt.object_id};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99, 0) >= m_idle_pct);
        end
    end

    // predictor and result monitor
    always @(posedge clk)
    begin
        request_t rq;
        check_t want;
        s_taken = s_tvalid && s_tready;
        if (s_taken)
        begin
            rq.func = s_tuser;
            rq.object_id = s_tdata[OBJ_W-1:0];
            rq.queue_id = s_tdata[OBJ_W+QID_W-1:OBJ_W];
            apply_request(rq);
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_checks.size() == 0)
                report("unexpected result", m_tdata[36:0], 0);
            else
            begin
                want = expected_checks.pop_front();
                if (m_tdata[0] !== want.rebalanced)
                    report("rebalanced", m_tdata[0], want.rebalanced);
                if (m_tdata[1] !== want.moved)
                    report("moved", m_tdata[1], want.moved);
                if (m_tdata[9:2] !== want.moved_object)
                    report("moved_object", m_tdata[9:2], want.moved_object);
                if (m_tdata[12:10] !== want.from_queue)
                    report("from_queue", m_tdata[12:10], want.from_queue);
                if (m_tdata[15:13] !== want.to_queue)
                    report("to_queue", m_tdata[15:13], want.to_queue);
                if (m_tdata[35:16] !== want.spread)
                    report("spread", m_tdata[35:16], want.spread);
                if (m_tdata[36] !== want.relaxed_mode)
                    report("relaxed_mode", m_tdata[36], want.relaxed_mode);
                if (m_tdata[52:37] !== want.streak)
                    report("streak", m_tdata[52:37], want.streak);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SPREAD_THR:  thr = val[19:0];
            REG_NORM_INTV:   norm_intv = val;
            REG_NORM_LIMIT:  norm_limit = val[15:0];
            REG_RELAX_INTV:  relax_intv = val;
            REG_RELAX_LIMIT: relax_limit = val[15:0];
            REG_QUEUES:      nq_reg = val[3:0];
            default:         nobj_reg = val[8:0];
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic send(logic [FUNC_W-1:0] f, int obj, int qid);
        request_t rq;
        rq.func = f;
        rq.object_id = obj[OBJ_W-1:0];
        rq.queue_id = qid[QID_W-1:0];
        pending_reqs.push_back(rq);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_checks.size() != 0)
            @(posedge clk);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    // settings per phase: threshold, intervals, streak limits, queues, objects
    logic [31:0] phase_cfg [7][7] = '{
        '{6554,       0,     4,     1,          2,     8,  200},
        '{0,          0,     0,     0,          0,     3,  16},
        '{1048575,    1,     65535, 2,          65535, 15, 9},
        '{30000,      2,     3,     0,          1,     0,  511},
        '{3000,       0,     2,     0,          3,     5,  0},
        '{6554, 32'hFFFFFFFF, 4, 32'hFFFFFFFF, 2,     8,  32},
        '{10000,      0,     1,     0,          1,     4,  24}
    };

    initial
    begin
        int f;
        int span;
        int roll_w;
        thr = 6554;
        norm_intv = 1000;
        norm_limit = 4;
        relax_intv = 4000;
        relax_limit = 2;
        nq_reg = 8;
        nobj_reg = 256;
        relaxed = 0;
        streak_cnt = '0;
        quiet = 0;
        for (int i = 0; i < MAX_QUEUES; i++)
        begin
            q_com[i] = 0; q_rol[i] = 0; q_com_b[i] = 0; q_rol_b[i] = 0;
        end
        for (int i = 0; i < MAX_OBJECTS; i++)
        begin
            o_com[i] = 0; o_rol[i] = 0; o_com_b[i] = 0; o_rol_b[i] = 0;
            owner[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 7; p++)
        begin
            if (p < 2)
            begin
                s_idle_pct = 6;
                m_idle_pct = 67;
            end
            else if (p < 4)
            begin
                s_idle_pct = 67;
                m_idle_pct = 6;
            end
            else
            begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            for (int r = 0; r < 7; r++)
                write_reg(r[CFG_IDX_W-1:0], phase_cfg[p][r]);
            if (p == 0)
            begin
                // out-of-range object, saturated negative metric, equal queues
                send(FUNC_ASSIGN, 1, 1);
                send(FUNC_ASSIGN, 2, 2);
                send(FUNC_ASSIGN, 255, 5);
                send(FUNC_COMMIT, 255, 0);
                send(FUNC_ROLL, 230, 0);
                send(FUNC_TICK, 0, 0);
                send(FUNC_COMMIT, 1, 0);
                for (int k = 0; k < 10; k++)
                    send(FUNC_ROLL, 1, 7);
                send(FUNC_COMMIT, 2, 0);
                send(FUNC_COMMIT, 2, 0);
                send(FUNC_ROLL, 2, 0);
                send(FUNC_COMMIT, 0, 0);
                send(FUNC_ASSIGN, 199, 7);
                send(FUNC_COMMIT, 199, 0);
                send(FUNC_TICK, 255, 7);
                send(FUNC_TICK, 0, 0);
            end
            span = objects_eff();
            roll_w = $urandom_range(15, 45);
            for (int k = 0; k < 55; k++)
            begin
                f = $urandom_range(99, 0);
                send(f < 18 ? FUNC_TICK : f < 55 ? FUNC_COMMIT :
                     f < 55 + roll_w ? FUNC_ROLL : FUNC_ASSIGN,
                     ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0)
                                                 : $urandom_range(span - 1, 0),
                     $urandom_range(7, 0));
            end
            drain();
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
